// File: src/mcog_pkg.sv
// Shared types, constants and the colour palette for the midpoint circle outline generator.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package mcog_pkg;

    localparam int MAX_RADIUS   = 64;
    localparam int PALETTE_SIZE = 8;
    localparam int MAX_RESULTS  = 48;

    localparam int CX_W    = 10;
    localparam int CY_W    = 10;
    localparam int RAD_W   = 8;
    localparam int KIND_W  = 8;
    localparam int COORD_W = 12;
    localparam int RGB_W   = 24;
    localparam int MAJ_W   = 9;   // signed x offset, may reach -1
    localparam int MIN_W   = 8;   // unsigned y offset
    localparam int INC_W   = 9;   // odd increments
    localparam int ERR_W   = 12;  // signed step error
    localparam int CNT_W   = 6;   // results per circle

    localparam logic [RAD_W-1:0] DIAM_MAX = RAD_W'(2 * MAX_RADIUS);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_RESULTS);
    localparam int PAL_IDX_W = $clog2(PALETTE_SIZE);

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_STEP = 1'b1
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;   // take a new circle from the input
        logic step;   // run one midpoint step and fill the output register
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic start_ok;   // incoming circle gives at least one result
        logic step_last;  // the step being taken now is the circle's last
    } dp_status_t;

    function automatic logic [RGB_W-1:0] palette_colour(input logic [PAL_IDX_W-1:0] idx);
        logic [RGB_W-1:0] c;
        case (idx)
            3'd0:    c = 24'h000000;
            3'd1:    c = 24'h9400D3;
            3'd2:    c = 24'h009E73;
            3'd3:    c = 24'h56B4E9;
            3'd4:    c = 24'hE69F00;
            3'd5:    c = 24'hF0E442;
            3'd6:    c = 24'h0072B2;
            3'd7:    c = 24'hE51E10;
            default: c = 24'h000000;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: src/mcog_ctrl.sv
// Controller state machine: input handshake, step sequencing and output valid.
// Depends on mcog_pkg for the state type and the command/status structs.
`timescale 1ns / 1ps
`default_nettype none

module mcog_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    input  wire mcog_pkg::dp_status_t status,
    output mcog_pkg::dp_cmd_t        cmd
);

    mcog_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    // state and output valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mcog_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb begin
        logic slot_free;
        slot_free      = !out_valid_reg || m_ready;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_ready;
        s_ready        = 1'b0;
        cmd.load       = 1'b0;
        cmd.step       = 1'b0;
        case (state_reg)
            mcog_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (status.start_ok) begin
                        state_next = mcog_pkg::ST_STEP;
                    end
                end
            end
            mcog_pkg::ST_STEP: begin
                if (slot_free) begin
                    cmd.step       = 1'b1;
                    out_valid_next = 1'b1;
                    if (status.step_last) begin
                        state_next = mcog_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = mcog_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: src/mcog_datapath.sv
// Datapath: held circle parameters, midpoint stepping registers and output payload register.
// Depends on mcog_pkg for widths, the palette function and the command/status structs.
`timescale 1ns / 1ps
`default_nettype none

module mcog_datapath (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire mcog_pkg::dp_cmd_t                   cmd,
    output mcog_pkg::dp_status_t                     status,
    input  wire logic [mcog_pkg::CX_W-1:0]           s_center_x,
    input  wire logic [mcog_pkg::CY_W-1:0]           s_center_y,
    input  wire logic [mcog_pkg::RAD_W-1:0]          s_radius_halves,
    input  wire logic [mcog_pkg::KIND_W-1:0]         s_circle_kind,
    output logic signed [mcog_pkg::COORD_W-1:0]      m_x_plus_major,
    output logic signed [mcog_pkg::COORD_W-1:0]      m_x_minus_major,
    output logic signed [mcog_pkg::COORD_W-1:0]      m_x_plus_minor,
    output logic signed [mcog_pkg::COORD_W-1:0]      m_x_minus_minor,
    output logic signed [mcog_pkg::COORD_W-1:0]      m_y_plus_minor,
    output logic signed [mcog_pkg::COORD_W-1:0]      m_y_minus_minor,
    output logic signed [mcog_pkg::COORD_W-1:0]      m_y_plus_major,
    output logic signed [mcog_pkg::COORD_W-1:0]      m_y_minus_major,
    output logic [mcog_pkg::RGB_W-1:0]               m_color_rgb,
    output logic                                     m_last_point
);

    localparam int CW = mcog_pkg::COORD_W;

    // held circle
    logic [mcog_pkg::CX_W-1:0]  cx_reg;
    logic [mcog_pkg::CY_W-1:0]  cy_reg;
    logic [mcog_pkg::RAD_W-1:0] diam_reg;
    logic [mcog_pkg::RGB_W-1:0] colour_reg;

    // stepping state
    logic signed [mcog_pkg::MAJ_W-1:0] maj_reg, maj_next;
    logic [mcog_pkg::MIN_W-1:0]        min_reg, min_next;
    logic [mcog_pkg::INC_W-1:0]        maj_inc_reg, maj_inc_next;
    logic [mcog_pkg::INC_W-1:0]        min_inc_reg, min_inc_next;
    logic signed [mcog_pkg::ERR_W-1:0] err_reg, err_next;
    logic [mcog_pkg::CNT_W-1:0]        cnt_reg, cnt_next;

    // output payload
    logic signed [CW-1:0] xpj_reg, xmj_reg, xpn_reg, xmn_reg;
    logic signed [CW-1:0] ypn_reg, ymn_reg, ypj_reg, ymj_reg;
    logic [mcog_pkg::RGB_W-1:0] rgb_reg;
    logic                       last_reg;

    // input conditioning: saturate the diameter, derive the start values
    logic [mcog_pkg::RAD_W-1:0]        diam_sat;
    logic signed [mcog_pkg::MAJ_W-1:0] maj_init;
    logic signed [mcog_pkg::ERR_W-1:0] err_init;

    always_comb begin
        diam_sat = (s_radius_halves > mcog_pkg::DIAM_MAX) ? mcog_pkg::DIAM_MAX
                                                          : s_radius_halves;
        maj_init = $signed({2'b00, diam_sat[mcog_pkg::RAD_W-1:1]})
                   - $signed(mcog_pkg::MAJ_W'(1));
        err_init = $signed(mcog_pkg::ERR_W'(1))
                   - $signed({{(mcog_pkg::ERR_W-mcog_pkg::RAD_W){1'b0}}, diam_sat});
    end

    // one midpoint step: minor advance, then major retreat
    logic signed [mcog_pkg::ERR_W-1:0] err_a;
    logic                              more;

    always_comb begin
        maj_next     = maj_reg;
        min_next     = min_reg;
        maj_inc_next = maj_inc_reg;
        min_inc_next = min_inc_reg;
        err_a        = err_reg;
        if (err_reg <= 0) begin
            min_next     = min_reg + 1'b1;
            err_a        = err_reg + $signed({3'b000, min_inc_reg});
            min_inc_next = min_inc_reg + mcog_pkg::INC_W'(2);
        end
        err_next = err_a;
        if (err_a > 0) begin
            maj_next     = maj_reg - $signed(mcog_pkg::MAJ_W'(1));
            maj_inc_next = maj_inc_reg + mcog_pkg::INC_W'(2);
            err_next     = err_a + $signed({3'b000, maj_inc_next})
                           - $signed({{(mcog_pkg::ERR_W-mcog_pkg::RAD_W){1'b0}}, diam_reg});
        end
        cnt_next = cnt_reg + 1'b1;
        more     = (maj_next >= $signed({1'b0, min_next})) && (cnt_next < mcog_pkg::CNT_MAX);
    end

    assign status.start_ok  = (maj_init >= 0);
    assign status.step_last = !more;

    // coordinate forming from the current offsets
    logic signed [CW-1:0] cx_e, cy_e, maj_e, min_e;

    always_comb begin
        cx_e  = $signed({{(CW-mcog_pkg::CX_W){1'b0}}, cx_reg});
        cy_e  = $signed({{(CW-mcog_pkg::CY_W){1'b0}}, cy_reg});
        maj_e = {{(CW-mcog_pkg::MAJ_W){maj_reg[mcog_pkg::MAJ_W-1]}}, maj_reg};
        min_e = $signed({{(CW-mcog_pkg::MIN_W){1'b0}}, min_reg});
    end

    // stepping registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            maj_reg     <= '0;
            min_reg     <= '0;
            maj_inc_reg <= mcog_pkg::INC_W'(1);
            min_inc_reg <= mcog_pkg::INC_W'(1);
            err_reg     <= '0;
            cnt_reg     <= '0;
        end else if (cmd.load) begin
            maj_reg     <= maj_init;
            min_reg     <= '0;
            maj_inc_reg <= mcog_pkg::INC_W'(1);
            min_inc_reg <= mcog_pkg::INC_W'(1);
            err_reg     <= err_init;
            cnt_reg     <= '0;
        end else if (cmd.step) begin
            maj_reg     <= maj_next;
            min_reg     <= min_next;
            maj_inc_reg <= maj_inc_next;
            min_inc_reg <= min_inc_next;
            err_reg     <= err_next;
            cnt_reg     <= cnt_next;
        end
    end

    // held circle parameters
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cx_reg     <= s_center_x;
            cy_reg     <= s_center_y;
            diam_reg   <= diam_sat;
            colour_reg <= mcog_pkg::palette_colour(s_circle_kind[mcog_pkg::PAL_IDX_W-1:0]);
        end
    end

    // output payload register
    always_ff @(posedge aclk) begin
        if (cmd.step) begin
            xpj_reg  <= cx_e + maj_e;
            xmj_reg  <= cx_e - maj_e;
            xpn_reg  <= cx_e + min_e;
            xmn_reg  <= cx_e - min_e;
            ypn_reg  <= cy_e + min_e;
            ymn_reg  <= cy_e - min_e;
            ypj_reg  <= cy_e + maj_e;
            ymj_reg  <= cy_e - maj_e;
            rgb_reg  <= colour_reg;
            last_reg <= !more;
        end
    end

    assign m_x_plus_major  = xpj_reg;
    assign m_x_minus_major = xmj_reg;
    assign m_x_plus_minor  = xpn_reg;
    assign m_x_minus_minor = xmn_reg;
    assign m_y_plus_minor  = ypn_reg;
    assign m_y_minus_minor = ymn_reg;
    assign m_y_plus_major  = ypj_reg;
    assign m_y_minus_major = ymj_reg;
    assign m_color_rgb     = rgb_reg;
    assign m_last_point    = last_reg;

endmodule

`default_nettype wire

// File: src/midpoint_circle_outline_generator.sv
// Midpoint circle outline generator: top level joining controller and datapath.
// Depends on mcog_pkg, mcog_ctrl and mcog_datapath.
//
// Usage:
//   Input channel (s_*): one item per circle - centre, radius in half pixels
//   (saturated to 128) and kind, whose low three bits pick the palette colour.
//   Output channel (m_*): one item per midpoint step, carrying the four x and
//   four y coordinates of the eight symmetric outline points, the colour and
//   m_last_point on the final step of the circle.
//   After acceptance the first result is formed in the step state, once the output register is free.
//   Throughput: one result per cycle while the receiver takes them; a circle of
//   N steps gives N results (N at most 48, about 46 for a radius of 64). The step
//   loop, one midpoint update per cycle while the output register is free, sets this.
//   A radius below one pixel gives no results and the block is ready again
//   in the next cycle.
//   s_ready is high only while no circle is being stepped; the next circle may
//   be accepted while the last result still waits in the output register.
//   When the receiver stalls, stepping pauses and the pending result holds.
//   Reset (aresetn low, synchronous) empties the output register and returns
//   the controller to idle.
`timescale 1ns / 1ps
`default_nettype none

module midpoint_circle_outline_generator (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [mcog_pkg::CX_W-1:0]           s_center_x,
    input  wire logic [mcog_pkg::CY_W-1:0]           s_center_y,
    input  wire logic [mcog_pkg::RAD_W-1:0]          s_radius_halves,
    input  wire logic [mcog_pkg::KIND_W-1:0]         s_circle_kind,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [mcog_pkg::COORD_W-1:0]      m_x_plus_major,
    output logic signed [mcog_pkg::COORD_W-1:0]      m_x_minus_major,
    output logic signed [mcog_pkg::COORD_W-1:0]      m_x_plus_minor,
    output logic signed [mcog_pkg::COORD_W-1:0]      m_x_minus_minor,
    output logic signed [mcog_pkg::COORD_W-1:0]      m_y_plus_minor,
    output logic signed [mcog_pkg::COORD_W-1:0]      m_y_minus_minor,
    output logic signed [mcog_pkg::COORD_W-1:0]      m_y_plus_major,
    output logic signed [mcog_pkg::COORD_W-1:0]      m_y_minus_major,
    output logic [mcog_pkg::RGB_W-1:0]               m_color_rgb,
    output logic                                     m_last_point
);

    mcog_pkg::dp_cmd_t    cmd;
    mcog_pkg::dp_status_t status;

    mcog_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mcog_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_center_x      (s_center_x),
        .s_center_y      (s_center_y),
        .s_radius_halves (s_radius_halves),
        .s_circle_kind   (s_circle_kind),
        .m_x_plus_major  (m_x_plus_major),
        .m_x_minus_major (m_x_minus_major),
        .m_x_plus_minor  (m_x_plus_minor),
        .m_x_minus_minor (m_x_minus_minor),
        .m_y_plus_minor  (m_y_plus_minor),
        .m_y_minus_minor (m_y_minus_minor),
        .m_y_plus_major  (m_y_plus_major),
        .m_y_minus_major (m_y_minus_major),
        .m_color_rgb     (m_color_rgb),
        .m_last_point    (m_last_point)
    );

endmodule

`default_nettype wire

// File: bench/tb_midpoint_circle_outline_generator.sv
// Self-checking bench for midpoint_circle_outline_generator: random circles in bursts,
// a stalling receiver and an outline tracer that predicts every step result.
// Depends on mcog_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_midpoint_circle_outline_generator;

    localparam int RANDOM_CIRCLES = 480;
    localparam int STALL_LIMIT    = 2000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int REPORT_MAX     = 10;

    typedef struct {
        logic [mcog_pkg::CX_W-1:0]   cx;
        logic [mcog_pkg::CY_W-1:0]   cy;
        logic [mcog_pkg::RAD_W-1:0]  radius_halves;
        logic [mcog_pkg::KIND_W-1:0] kind;
        bit                          drain_first;  // hold off until all results are in
    } circle_t;

    typedef struct packed {
        logic signed [mcog_pkg::COORD_W-1:0] x_plus_major;
        logic signed [mcog_pkg::COORD_W-1:0] x_minus_major;
        logic signed [mcog_pkg::COORD_W-1:0] x_plus_minor;
        logic signed [mcog_pkg::COORD_W-1:0] x_minus_minor;
        logic signed [mcog_pkg::COORD_W-1:0] y_plus_minor;
        logic signed [mcog_pkg::COORD_W-1:0] y_minus_minor;
        logic signed [mcog_pkg::COORD_W-1:0] y_plus_major;
        logic signed [mcog_pkg::COORD_W-1:0] y_minus_major;
        logic [mcog_pkg::RGB_W-1:0]          rgb;
        logic                                last;
    } outline_point_t;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_ONE_IN_FOUR
    } rx_mode_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                        s_valid         = 1'b0;
    logic                        s_ready;
    logic [mcog_pkg::CX_W-1:0]   s_center_x      = '0;
    logic [mcog_pkg::CY_W-1:0]   s_center_y      = '0;
    logic [mcog_pkg::RAD_W-1:0]  s_radius_halves = '0;
    logic [mcog_pkg::KIND_W-1:0] s_circle_kind   = '0;
    logic                        m_valid;
    logic                        m_ready         = 1'b0;
    logic signed [mcog_pkg::COORD_W-1:0] m_x_plus_major, m_x_minus_major;
    logic signed [mcog_pkg::COORD_W-1:0] m_x_plus_minor, m_x_minus_minor;
    logic signed [mcog_pkg::COORD_W-1:0] m_y_plus_minor, m_y_minus_minor;
    logic signed [mcog_pkg::COORD_W-1:0] m_y_plus_major, m_y_minus_major;
    logic [mcog_pkg::RGB_W-1:0]          m_color_rgb;
    logic                                m_last_point;

    circle_t        pending_circles[$];
    circle_t        circle_on_bus;
    outline_point_t awaited_points[$];

    logic [mcog_pkg::RGB_W-1:0] colour_table [mcog_pkg::PALETTE_SIZE] = '{
        24'h000000, 24'h9400D3, 24'h009E73, 24'h56B4E9,
        24'hE69F00, 24'hF0E442, 24'h0072B2, 24'hE51E10
    };

    int       mismatches = 0;
    int       burst_left = 0;
    int       gap_left   = 0;
    int       mode_left  = 0;
    int       quiet_cycles = 0;
    int       rx_phase   = 0;
    rx_mode_t rx_mode    = RX_ALWAYS;

    midpoint_circle_outline_generator DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_center_x      (s_center_x),
        .s_center_y      (s_center_y),
        .s_radius_halves (s_radius_halves),
        .s_circle_kind   (s_circle_kind),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_x_plus_major  (m_x_plus_major),
        .m_x_minus_major (m_x_minus_major),
        .m_x_plus_minor  (m_x_plus_minor),
        .m_x_minus_minor (m_x_minus_minor),
        .m_y_plus_minor  (m_y_plus_minor),
        .m_y_minus_minor (m_y_minus_minor),
        .m_y_plus_major  (m_y_plus_major),
        .m_y_minus_major (m_y_minus_major),
        .m_color_rgb     (m_color_rgb),
        .m_last_point    (m_last_point)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Walk the midpoint error stepping of one circle, queueing a result per step
    function automatic void trace_outline(circle_t c);
        int diam;
        int ox;
        int oy;
        int inc_major;
        int inc_minor;
        int err;
        int steps;
        int cx;
        int cy;
        bit more;
        outline_point_t p;
        diam = (c.radius_halves > 2 * mcog_pkg::MAX_RADIUS) ? 2 * mcog_pkg::MAX_RADIUS
                                                             : int'(c.radius_halves);
        cx = int'(c.cx);
        cy = int'(c.cy);
        ox = (diam >> 1) - 1;
        oy = 0;
        inc_major = 1;
        inc_minor = 1;
        err = 1 - diam;
        steps = 0;
        more = (ox >= oy);
        while (more) begin
            p.x_plus_major  = mcog_pkg::COORD_W'(cx + ox);
            p.x_minus_major = mcog_pkg::COORD_W'(cx - ox);
            p.x_plus_minor  = mcog_pkg::COORD_W'(cx + oy);
            p.x_minus_minor = mcog_pkg::COORD_W'(cx - oy);
            p.y_plus_minor  = mcog_pkg::COORD_W'(cy + oy);
            p.y_minus_minor = mcog_pkg::COORD_W'(cy - oy);
            p.y_plus_major  = mcog_pkg::COORD_W'(cy + ox);
            p.y_minus_major = mcog_pkg::COORD_W'(cy - ox);
            p.rgb           = colour_table[c.kind % mcog_pkg::PALETTE_SIZE];
            if (err <= 0) begin
                oy++;
                err += inc_minor;
                inc_minor += 2;
            end
            if (err > 0) begin
                ox--;
                inc_major += 2;
                err += inc_major - diam;
            end
            steps++;
            more = (ox >= oy) && (steps < mcog_pkg::MAX_RESULTS);
            p.last = !more;
            awaited_points = {awaited_points, p};
        end
    endfunction

    function automatic void check_field(string name, logic [mcog_pkg::RGB_W-1:0] want,
                                        logic [mcog_pkg::RGB_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("%0t: %s expected %h, got %h", $realtime, name, want, got);
        end
    endfunction

    function automatic circle_t make_circle(int cx, int cy, int rad, int kind, bit drain);
        circle_t c;
        c.cx            = mcog_pkg::CX_W'(cx);
        c.cy            = mcog_pkg::CY_W'(cy);
        c.radius_halves = mcog_pkg::RAD_W'(rad);
        c.kind          = mcog_pkg::KIND_W'(kind);
        c.drain_first   = drain;
        return c;
    endfunction

    // append one circle to the send queue
    function automatic void queue_circle(circle_t c);
        pending_circles = {pending_circles, c};
    endfunction

    // Stimulus: directed corners first, then random circles
    initial begin
        int rad;
        int pick;
        // sub-pixel radii give nothing; radius one pixel gives a single step
        queue_circle(make_circle(0, 0, 0, 0, 0));
        queue_circle(make_circle(1023, 1023, 1, 1, 0));
        queue_circle(make_circle(512, 512, 2, 2, 0));
        queue_circle(make_circle(300, 700, 3, 3, 0));
        queue_circle(make_circle(700, 300, 4, 4, 0));
        queue_circle(make_circle(5, 1018, 5, 5, 0));
        // largest radius at the corners, coordinates go negative and past 1023
        queue_circle(make_circle(0, 0, 128, 6, 0));
        queue_circle(make_circle(1023, 1023, 128, 7, 1));
        // oversized radii are clamped, mixed with in-range radii and kinds above seven
        queue_circle(make_circle(500, 500, 129, 8, 0));
        queue_circle(make_circle(1023, 0, 255, 255, 0));
        queue_circle(make_circle(0, 1023, 127, 15, 0));
        queue_circle(make_circle(10, 10, 200, 128, 0));
        queue_circle(make_circle(341, 682, 1, 170, 0));
        queue_circle(make_circle(682, 341, 64, 85, 1));

        for (int i = 0; i < RANDOM_CIRCLES; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                rad = $urandom_range(0, 40);
            else if (pick < 85)
                rad = $urandom_range(41, 128);
            else
                rad = $urandom_range(129, 255);
            queue_circle(make_circle($urandom_range(0, 1023),
                                     $urandom_range(0, 1023), rad,
                                     $urandom_range(0, 255),
                                     (i % 97) == 50));
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Sender: bursts of circles with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (s_valid && s_ready)
                trace_outline(circle_on_bus);
            if (!(s_valid && !s_ready)) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (pending_circles.size() != 0 &&
                             (!pending_circles[0].drain_first ||
                              awaited_points.size() == 0)) begin
                    circle_on_bus = pending_circles.pop_front();
                    s_center_x      <= circle_on_bus.cx;
                    s_center_y      <= circle_on_bus.cy;
                    s_radius_halves <= circle_on_bus.radius_halves;
                    s_circle_kind   <= circle_on_bus.kind;
                    s_valid         <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern switches between modes at random intervals
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            mode_left <= 0;
        end else begin
            rx_phase <= rx_phase + 1;
            if (mode_left == 0) begin
                rx_mode   <= rx_mode_t'($urandom_range(0, 2));
                mode_left <= $urandom_range(32, 256);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (rx_mode)
                RX_ALWAYS:      m_ready <= 1'b1;
                RX_COIN:        m_ready <= ($urandom_range(0, 9) < 6);
                RX_ONE_IN_FOUR: m_ready <= (rx_phase % 4 == 0);
                default:        m_ready <= 1'b1;
            endcase
        end
    end

    // Result checker
    always @(posedge aclk) begin
        outline_point_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_points.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: result item with nothing awaited", $realtime);
            end else begin
                want = awaited_points.pop_front();
                check_field("x_plus_major", mcog_pkg::RGB_W'(want.x_plus_major),
                            mcog_pkg::RGB_W'(m_x_plus_major));
                check_field("x_minus_major", mcog_pkg::RGB_W'(want.x_minus_major),
                            mcog_pkg::RGB_W'(m_x_minus_major));
                check_field("x_plus_minor", mcog_pkg::RGB_W'(want.x_plus_minor),
                            mcog_pkg::RGB_W'(m_x_plus_minor));
                check_field("x_minus_minor", mcog_pkg::RGB_W'(want.x_minus_minor),
                            mcog_pkg::RGB_W'(m_x_minus_minor));
                check_field("y_plus_minor", mcog_pkg::RGB_W'(want.y_plus_minor),
                            mcog_pkg::RGB_W'(m_y_plus_minor));
                check_field("y_minus_minor", mcog_pkg::RGB_W'(want.y_minus_minor),
                            mcog_pkg::RGB_W'(m_y_minus_minor));
                check_field("y_plus_major", mcog_pkg::RGB_W'(want.y_plus_major),
                            mcog_pkg::RGB_W'(m_y_plus_major));
                check_field("y_minus_major", mcog_pkg::RGB_W'(want.y_minus_major),
                            mcog_pkg::RGB_W'(m_y_minus_major));
                check_field("color_rgb", want.rgb, m_color_rgb);
                check_field("last_point", mcog_pkg::RGB_W'(want.last),
                            mcog_pkg::RGB_W'(m_last_point));
            end
        end
    end

    // Watchdog on cycles with no handshake on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("midpoint_circle_outline_generator: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // End of run: all circles sent, all results in, then a short settle
    initial begin
        @(posedge aresetn);
        @(posedge aclk);
        while (pending_circles.size() != 0 || s_valid || awaited_points.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && awaited_points.size() == 0)
            $display("midpoint_circle_outline_generator: match");
        else
            $display("midpoint_circle_outline_generator: mismatch");
        $finish;
    end

endmodule

// File: midpoint_circle_outline_generator.f
src/mcog_pkg.sv
src/mcog_ctrl.sv
src/mcog_datapath.sv
src/midpoint_circle_outline_generator.sv
bench/tb_midpoint_circle_outline_generator.sv
